/* hdl/log2_latency_histogram_unit_defines.svh */
// Assertion macros used by the checker file.
`ifndef LOG2_LATENCY_HISTOGRAM_UNIT_DEFINES_SVH
`define LOG2_LATENCY_HISTOGRAM_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LLH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define LLH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/llh_pkg.sv */
package llh_pkg;

    localparam int BUCKETS_DEF = 64;
    localparam int DATA_W      = 64;
    localparam int CMD_W       = 2;
    localparam int PCT_W       = 14;
    localparam int LOG_W       = 6;
    localparam int PROD_W      = DATA_W + PCT_W;
    localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(10000);

    typedef enum logic [CMD_W-1:0] {
        CMD_RECORD = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] sample_ns;
        logic [PCT_W-1:0]  pct_hundredths;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] pct_value;
        logic [DATA_W-1:0] count_total;
        logic [DATA_W-1:0] sum_total;
    } out_item_t;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } qry_status_t;

    function automatic logic [LOG_W-1:0] floor_log2(input logic [DATA_W-1:0] v);
        logic [LOG_W-1:0] r;
        r = '0;
        for (int i = 1; i < DATA_W; i++) begin
            if (v[i])
            begin
                r = LOG_W'(i);
            end
        end
        return r;
    endfunction

    // bucket 0 -> 0, bucket i -> 2^(i-1)
    function automatic logic [DATA_W-1:0] bucket_value(input logic [LOG_W-1:0] i);
        logic [DATA_W-1:0] v;
        v = '0;
        if (i != '0)
        begin
            v = DATA_W'(1) << (i - LOG_W'(1));
        end
        return v;
    endfunction

endpackage

/* hdl/log2_latency_histogram_unit.sv */
// Record: one transaction per cycle while no query is in progress; the bucket is read at accept
//   and written back on the next edge, with forwarding of the last write-back for back-to-back hits.
// Clear: count, sum and all bucket valid bits drop at once.
// Query: empty/0%/full give the result straight from the idle state; otherwise a divide by 10000
//   and a walk with one read per bucket until the running count reaches the target; input stalls meanwhile.
// Reset: asynchronous, active low; counters and valid bits cleared, memory not swept.
module log2_latency_histogram_unit
    import llh_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF,
    localparam int IDX_W  = $clog2(BUCKETS)
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    localparam logic [LOG_W-1:0] LAST_LOG = LOG_W'(BUCKETS-1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUCKETS-1);

    qry_status_t       qst;
    logic              accept;
    logic              rec, clr, qry;
    logic [LOG_W-1:0]  lg;
    logic [IDX_W-1:0]  rec_idx;

    logic              wb_vld_reg;
    logic [IDX_W-1:0]  wb_idx_reg;
    logic              fwd_vld_reg;
    logic [IDX_W-1:0]  fwd_idx_reg;
    logic [DATA_W-1:0] fwd_data_reg;
    logic [DATA_W-1:0] wb_base;
    logic [DATA_W-1:0] wb_data;

    logic [DATA_W-1:0] count_reg, count_next;
    logic [DATA_W-1:0] sum_reg, sum_next;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              rd_hit;
    logic              walk_rd_en;
    logic [IDX_W-1:0]  walk_addr;
    logic [DATA_W-1:0] res_value;
    logic              res_take;

    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg;

    assign in_ready = qst.idle;
    assign accept   = in_valid && in_ready;
    assign rec      = accept && (in_item.cmd == CMD_RECORD);
    assign qry      = accept && (in_item.cmd == CMD_QUERY);
    assign clr      = accept && (in_item.cmd == CMD_CLEAR);

    assign lg      = floor_log2(in_item.sample_ns);
    assign rec_idx = (lg >= LAST_LOG) ? LAST_IDX : lg[IDX_W-1:0];

    assign rd_en   = rec || walk_rd_en;
    assign rd_addr = walk_rd_en ? walk_addr : rec_idx;

    assign wb_base = (fwd_vld_reg && (fwd_idx_reg == wb_idx_reg)) ? fwd_data_reg
                   : (rd_hit ? rd_data : '0);
    assign wb_data = wb_base + DATA_W'(1);

    llh_bucket_store #(
        .BUCKETS (BUCKETS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr     (clr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .rd_hit  (rd_hit),
        .wr_en   (wb_vld_reg),
        .wr_addr (wb_idx_reg),
        .wr_data (wb_data)
    );

    llh_query_ctrl #(
        .BUCKETS (BUCKETS)
    ) u_qry (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (qry),
        .pct        (in_item.pct_hundredths),
        .count      (count_reg),
        .rd_data    (rd_data),
        .rd_hit     (rd_hit),
        .walk_rd_en (walk_rd_en),
        .walk_addr  (walk_addr),
        .res_take   (res_take),
        .status     (qst),
        .res_value  (res_value)
    );

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        if (clr)
        begin
            count_next = '0;
            sum_next   = '0;
        end
        else if (rec)
        begin
            count_next = count_reg + DATA_W'(1);
            sum_next   = sum_reg + in_item.sample_ns;
        end
    end

    assign res_take = qst.res_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_vld_reg    <= 1'b0;
            fwd_vld_reg   <= 1'b0;
            count_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wb_vld_reg    <= rec;
            fwd_vld_reg   <= clr ? 1'b0 : (wb_vld_reg || fwd_vld_reg);
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec)
        begin
            wb_idx_reg <= rec_idx;
        end
        if (wb_vld_reg)
        begin
            fwd_idx_reg  <= wb_idx_reg;
            fwd_data_reg <= wb_data;
        end
        if (res_take)
        begin
            out_item_reg.pct_value   <= res_value;
            out_item_reg.count_total <= count_reg;
            out_item_reg.sum_total   <= sum_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

/* hdl/llh_divider.sv */
module llh_divider
    import llh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    output logic              done,
    output logic [PROD_W-1:0] quotient
);

    localparam int DIG_W   = 16;
    localparam int NDIG    = (PROD_W + DIG_W - 1) / DIG_W;
    localparam int PAD_W   = NDIG * DIG_W;
    localparam int X_W     = PCT_W + DIG_W;
    localparam int SHIFT   = X_W + PCT_W;
    localparam int RECIP_W = 31;
    localparam int MUL_W   = X_W + RECIP_W;
    localparam int CNT_W   = $clog2(NDIG);
    localparam int DIVISOR = 10000;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(DIVISOR - 1)) / 64'(DIVISOR));

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PCT_W-1:0]  rem_reg, rem_next;
    logic [DIG_W-1:0]  q_reg, q_next;
    logic [PAD_W-1:0]  dvd_reg, dvd_next;
    logic [X_W-1:0]    x;
    logic [MUL_W-1:0]  prod;

    // long division by 10000 in 16-bit digits, each digit in turn:
    // quotient digit by reciprocal multiply, then remainder update and shift
    always_comb
    begin
        x          = {rem_reg, dvd_reg[PAD_W-1 -: DIG_W]};
        prod       = MUL_W'(x) * MUL_W'(RECIP);
        busy_next  = busy_reg;
        done_next  = 1'b0;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        dvd_next   = dvd_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
            cnt_next   = '0;
            rem_next   = '0;
            dvd_next   = PAD_W'(dividend);
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                q_next     = prod[SHIFT +: DIG_W];
                phase_next = 1'b1;
            end
            else
            begin
                rem_next   = PCT_W'(x - X_W'(q_reg) * X_W'(DIVISOR));
                dvd_next   = {dvd_reg[PAD_W-DIG_W-1:0], q_reg};
                cnt_next   = cnt_reg + CNT_W'(1);
                phase_next = 1'b0;
                if (cnt_reg == CNT_W'(NDIG-1))
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dvd_reg <= dvd_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg[PROD_W-1:0];

endmodule

/* hdl/llh_bucket_store.sv */
module llh_bucket_store
    import llh_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF,
    localparam int IDX_W  = $clog2(BUCKETS)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clr,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    output logic [DATA_W-1:0] rd_data,
    output logic              rd_hit,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0]  mem [BUCKETS];
    logic [DATA_W-1:0]  rd_data_reg;
    logic [BUCKETS-1:0] vld_reg, vld_next;
    logic               rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // an entry not marked valid reads with rd_hit low; clear wins over a same-cycle write
    always_comb
    begin
        vld_next = vld_reg;
        if (clr)
        begin
            vld_next = '0;
        end
        else if (wr_en)
        begin
            vld_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (rd_en)
            begin
                rd_hit_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign rd_hit  = rd_hit_reg;

endmodule

/* hdl/llh_query_ctrl.sv */
module llh_query_ctrl
    import llh_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF,
    localparam int IDX_W  = $clog2(BUCKETS)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PCT_W-1:0]  pct,
    input  logic [DATA_W-1:0] count,
    input  logic [DATA_W-1:0] rd_data,
    input  logic              rd_hit,
    output logic              walk_rd_en,
    output logic [IDX_W-1:0]  walk_addr,
    input  logic              res_take,
    output qry_status_t       status,
    output logic [DATA_W-1:0] res_value
);

    typedef enum logic [3:0] {
        Q_IDLE = 4'b0001,
        Q_DIV  = 4'b0010,
        Q_WALK = 4'b0100,
        Q_RES  = 4'b1000
    } qstate_t;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(BUCKETS-1);
    localparam logic [IDX_W:0]   WALK_END  = (IDX_W+1)'(BUCKETS);
    localparam logic [DATA_W-1:0] FULL_VAL = DATA_W'(1) << (BUCKETS-1);
    localparam logic [DATA_W-1:0] MISS_VAL = DATA_W'(1) << (BUCKETS-2);

    qstate_t           state_reg, state_next;
    logic [DATA_W-1:0] target_reg, target_next;
    logic [DATA_W-1:0] seen_reg, seen_next;
    logic [IDX_W:0]    ra_reg, ra_next;
    logic              dv_reg, dv_next;
    logic [IDX_W-1:0]  didx_reg, didx_next;
    logic [DATA_W-1:0] res_reg, res_next;
    logic [DATA_W-1:0] seen_sum;
    logic              div_start;
    logic              div_done;
    logic [PROD_W-1:0] product;
    logic [PROD_W-1:0] quotient;

    assign product = PROD_W'(count) * PROD_W'(pct);

    llh_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next  = state_reg;
        target_next = target_reg;
        seen_next   = seen_reg;
        ra_next     = ra_reg;
        dv_next     = 1'b0;
        didx_next   = didx_reg;
        res_next    = res_reg;
        div_start   = 1'b0;
        walk_rd_en  = 1'b0;
        seen_sum    = seen_reg + (rd_hit ? rd_data : '0);
        unique case (state_reg)
            Q_IDLE:
            begin
                if (start)
                begin
                    if (count == '0)
                    begin
                        res_next   = '0;
                        state_next = Q_RES;
                    end
                    else if (pct == '0)
                    begin
                        res_next   = DATA_W'(1);
                        state_next = Q_RES;
                    end
                    else if (pct >= PCT_FULL)
                    begin
                        res_next   = FULL_VAL;
                        state_next = Q_RES;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = Q_DIV;
                    end
                end
            end
            Q_DIV:
            begin
                if (div_done)
                begin
                    target_next = (quotient[DATA_W-1:0] == '0) ? DATA_W'(1)
                                                               : quotient[DATA_W-1:0];
                    seen_next   = '0;
                    ra_next     = '0;
                    state_next  = Q_WALK;
                end
            end
            Q_WALK:
            begin
                if (ra_reg < WALK_END)
                begin
                    walk_rd_en = 1'b1;
                    ra_next    = ra_reg + (IDX_W+1)'(1);
                    dv_next    = 1'b1;
                    didx_next  = ra_reg[IDX_W-1:0];
                end
                if (dv_reg)
                begin
                    seen_next = seen_sum;
                    if (seen_sum >= target_reg)
                    begin
                        res_next   = bucket_value(LOG_W'(didx_reg));
                        dv_next    = 1'b0;
                        state_next = Q_RES;
                    end
                    else if (didx_reg == LAST_IDX)
                    begin
                        res_next   = MISS_VAL;
                        dv_next    = 1'b0;
                        state_next = Q_RES;
                    end
                end
            end
            Q_RES:
            begin
                if (res_take)
                begin
                    state_next = Q_IDLE;
                end
            end
            default:
            begin
                state_next = Q_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= Q_IDLE;
            dv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dv_reg    <= dv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg <= target_next;
        seen_reg   <= seen_next;
        ra_reg     <= ra_next;
        didx_reg   <= didx_next;
        res_reg    <= res_next;
    end

    assign walk_addr        = ra_reg[IDX_W-1:0];
    assign status.idle      = (state_reg == Q_IDLE);
    assign status.res_valid = (state_reg == Q_RES);
    assign res_value        = res_reg;

endmodule

/* hdl/llh_checker.sv */
`include "log2_latency_histogram_unit_defines.svh"

module llh_checker
    import llh_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_item_t  in_item,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_item
);

    `LLH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "result transaction dropped or changed while stalled")

    `LLH_ASSERT_NOW(a_ready_fall, $fell(in_ready), $past(in_valid && (in_item.cmd == CMD_QUERY)), "input stalled without a query")

    `LLH_ASSERT_NOW(a_out_rise, $rose(out_valid), $past(!in_ready), "result with no query in progress")

    `LLH_ASSERT_NOW(a_pct_pow2, out_valid, $onehot0(out_item.pct_value), "percentile value not a power of two")

    `LLH_ASSERT_NOW(a_empty_zero, out_valid && (out_item.count_total == '0), out_item.pct_value == '0, "empty histogram gave nonzero percentile")

endmodule

bind log2_latency_histogram_unit llh_checker u_llh_checker (.*);
